>>> rtl/kil_pkg.sv
// ----------------------------------------------------------------------------
// kil_pkg
// Types, token codes and keyword constants shared by the lexer modules.
// ----------------------------------------------------------------------------
package kil_pkg;

  localparam int MAX_IDENT_LEN = 255;
  // The length field is 8 bits wide, so the count also stops at 255.
  localparam int LEN_CAP_INT   = (MAX_IDENT_LEN < 255) ? MAX_IDENT_LEN : 255;
  localparam logic [7:0] LEN_CAP = 8'(LEN_CAP_INT);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    KIND_IDENT    = 3'd0,
    KIND_TASK     = 3'd1,
    KIND_DEADLINE = 3'd2,
    KIND_PRIORITY = 3'd3,
    KIND_BAD      = 3'd4,
    KIND_END      = 3'd5
  } kil_kind_t;

  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_UNDER = 8'h5F;

  localparam logic [2:0] CAND_ALL = 3'b111;

  // Keyword spelling, one row per keyword, zero padded to 8 characters.
  localparam logic [7:0] KW_TEXT [3][8] = '{
    '{8'h74, 8'h61, 8'h73, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h00},  // task
    '{8'h64, 8'h65, 8'h61, 8'h64, 8'h6C, 8'h69, 8'h6E, 8'h65},  // deadline
    '{8'h70, 8'h72, 8'h69, 8'h6F, 8'h72, 8'h69, 8'h74, 8'h79}   // priority
  };
  localparam logic [7:0] KW_LEN [3] = '{8'd4, 8'd8, 8'd8};

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } kil_in_t;

  typedef struct packed {
    kil_kind_t   token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [7:0]  token_length;
    logic        last_of_run;
  } kil_out_t;

  // Results produced by one item: up to two, in order.
  typedef struct packed {
    kil_out_t   res0;
    kil_out_t   res1;
    logic [1:0] count;
  } kil_res_t;

endpackage

>>> rtl/kil_scan.sv
// ----------------------------------------------------------------------------
// kil_scan
// Scanner state and the per-item token logic: position tracking, comment
// skipping, identifier collection and keyword matching.
// ----------------------------------------------------------------------------
module kil_scan
  import kil_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  kil_in_t  item,
  output kil_res_t res
);

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_IDENT   = 2'd2
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [15:0] line_r, line_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] sline_r, sline_nxt;
  logic [15:0] scol_r, scol_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [2:0]  cand_r, cand_nxt;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_letter(c) || (c >= 8'h30 && c <= 8'h39) || (c == CHAR_UNDER);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  // Drop every keyword that cannot match once character c sits at place len.
  function automatic logic [2:0] narrow(input logic [2:0] cand, input logic [7:0] len,
                                        input logic [7:0] c);
    logic [2:0] n;
    n = cand;
    for (int k = 0; k < 3; k++) begin
      if (len >= KW_LEN[k] || KW_TEXT[k][len[2:0]] != c) begin
        n[k] = 1'b0;
      end
    end
    return n;
  endfunction

  logic [7:0] c;
  logic       eoi;
  logic       ident_end;
  logic       have_ident, have_tok;
  kil_kind_t  ident_kind;
  kil_out_t   ident_res, tok_res;
  logic       adv;

  assign c   = item.char_code;
  assign eoi = item.end_of_input;

  always_comb begin
    mode_nxt   = mode_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    sline_nxt  = sline_r;
    scol_nxt   = scol_r;
    len_nxt    = len_r;
    cand_nxt   = cand_r;
    have_ident = 1'b0;
    have_tok   = 1'b0;
    adv        = 1'b0;
    ident_end  = (mode_r == MODE_IDENT) && (eoi || !is_word(c));

    ident_kind = KIND_IDENT;
    if (cand_r[0] && len_r == KW_LEN[0]) ident_kind = KIND_TASK;
    if (cand_r[1] && len_r == KW_LEN[1]) ident_kind = KIND_DEADLINE;
    if (cand_r[2] && len_r == KW_LEN[2]) ident_kind = KIND_PRIORITY;

    ident_res = '{token_kind: ident_kind, start_line: sline_r, start_column: scol_r,
                  token_length: len_r, last_of_run: 1'b0};
    tok_res   = '{token_kind: KIND_END, start_line: line_r, start_column: col_r,
                  token_length: 8'd0, last_of_run: 1'b1};

    if (mode_r == MODE_IDENT && !ident_end) begin
      cand_nxt = narrow(cand_r, len_r, c);
      if (len_r < LEN_CAP) len_nxt = len_r + 8'd1;
      adv = 1'b1;
    end else begin
      if (ident_end) begin
        have_ident = 1'b1;
        mode_nxt   = MODE_NORMAL;
        cand_nxt   = CAND_ALL;
      end
      if (eoi) begin
        have_tok = 1'b1;
        mode_nxt = MODE_NORMAL;
      end else if (mode_r == MODE_COMMENT) begin
        if (c == CHAR_NL) mode_nxt = MODE_NORMAL;
        adv = 1'b1;
      end else if (is_space(c)) begin
        adv = 1'b1;
      end else if (c == CHAR_HASH) begin
        mode_nxt = MODE_COMMENT;
        adv      = 1'b1;
      end else if (is_letter(c)) begin
        mode_nxt  = MODE_IDENT;
        sline_nxt = line_r;
        scol_nxt  = col_r;
        cand_nxt  = narrow(CAND_ALL, 8'd0, c);
        len_nxt   = (LEN_CAP > 8'd0) ? 8'd1 : 8'd0;
        adv       = 1'b1;
      end else begin
        have_tok              = 1'b1;
        tok_res.token_kind    = KIND_BAD;
        tok_res.token_length  = 8'd1;
        adv                   = 1'b1;
      end
    end

    if (adv) begin
      if (c == CHAR_NL) begin
        if (line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
        col_nxt = 16'd1;
      end else if (col_r != 16'hFFFF) begin
        col_nxt = col_r + 16'd1;
      end
    end

    // The identifier result is last only when no second token follows it.
    ident_res.last_of_run = !have_tok;
    res.res0  = have_ident ? ident_res : tok_res;
    res.res1  = tok_res;
    res.count = {1'b0, have_ident} + {1'b0, have_tok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      line_r  <= 16'd1;
      col_r   <= 16'd0;
      sline_r <= 16'd0;
      scol_r  <= 16'd0;
      len_r   <= 8'd0;
      cand_r  <= CAND_ALL;
    end else if (step) begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      sline_r <= sline_nxt;
      scol_r  <= scol_nxt;
      len_r   <= len_nxt;
      cand_r  <= cand_nxt;
    end
  end

endmodule

>>> rtl/kil_out_fifo.sv
// ----------------------------------------------------------------------------
// kil_out_fifo
// Small result queue: takes up to two results in a cycle, gives one.
// ----------------------------------------------------------------------------
module kil_out_fifo
  import kil_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  kil_res_t wr,
  output logic     room,
  output logic     out_valid,
  input  logic     out_ready,
  output kil_out_t out_item
);

  kil_out_t           mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               pop;
  logic [1:0]         n_push;

  // Room for a full two-result item, decided from registered state only.
  assign room      = (cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign n_push    = push ? wr.count : 2'd0;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(n_push);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    cnt_nxt    = cnt_r + (FIFO_AW+1)'(n_push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= wr.res0;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_ptr_r + FIFO_AW'(1)] <= wr.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> rtl/keyword_identifier_lexer.sv
// ----------------------------------------------------------------------------
// keyword_identifier_lexer
// Character scanner that reports identifiers, the keywords task, deadline
// and priority, unrecognized characters and end of input, with positions.
// ----------------------------------------------------------------------------
//   channel | ports                            | payload
//   input   | in_valid, in_ready, in_item      | kil_in_t (char_code, end_of_input)
//   result  | out_valid, out_ready, out_item   | kil_out_t (token fields, last_of_run)
//
// One item is taken per cycle while the queue has room; its first result
// leaves through the input register, then the result queue.
// An item that closes an identifier and also yields a token writes two
// results, so a long run of such items is bounded by the one-result-per-cycle
// output port; the four-entry queue stops input once it holds three or more.
// Reset clears the scanner state, the input register and the queue.
// ----------------------------------------------------------------------------
module keyword_identifier_lexer
  import kil_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  kil_in_t  in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output kil_out_t out_item
);

  logic     in_valid_r;
  kil_in_t  in_item_r;
  logic     room;
  logic     step;
  kil_res_t res;

  assign step     = in_valid_r && room;
  assign in_ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_item;
    end
  end

  kil_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_item_r),
    .res   (res)
  );

  kil_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .wr        (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
